>>> hdl/ofc_pkg.sv
// Shared constants, types and small lookup functions for the flow color coder.
package ofc_pkg;

  // Defaults for the top-level parameters
  localparam int FLOW_WIDTH_DEF     = 16;
  localparam int FLOW_FRAC_BITS_DEF = 12;

  // Gain register
  localparam int              GAIN_WIDTH = 12;
  localparam logic [11:0]     GAIN_RESET = 12'd255;

  // Angle and value resolution
  localparam int              ANGLE_STEPS     = 22;
  localparam int              VALUE_BITS      = 8;
  localparam int              MAG_SQ_WIDTH    = 16;
  localparam logic [5:0]      IDX_STEEP_START = 6'd22;
  localparam logic [7:0]      HUE_ZERO_VECTOR = 8'd90;
  localparam logic [7:0]      QUAD_SPAN       = 8'd45;

  // HSV to BGR
  localparam logic [4:0]      SECTOR_SPAN = 5'd30;
  localparam logic [14:0]     ROUND_HALF  = 15'd30;
  // floor(n / 60) = (n * DIV60_RECIP) >> DIV60_SHIFT, exact for n < 23831
  localparam logic [14:0]     DIV60_RECIP = 15'd17477;
  localparam int              DIV60_SHIFT = 20;

  // Hue sectors of 60 degrees (30 hue steps)
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // Per-item info that rides along the cell chain
  typedef struct packed {
    logic                    zero;    // both components zero
    logic                    steep;   // minor axis larger than major axis
    logic [1:0]              quad;    // quadrant of the reversed vector
    logic [5:0]              idx;     // 2-degree steps inside the quadrant
    logic [MAG_SQ_WIDTH-1:0] mag_sq;  // (gain*|flow|)^2 in integer units, saturated
    logic [VALUE_BITS-1:0]   value;   // value channel, built MSB first
  } ofc_tag_t;

  // tan(2k degrees) in unsigned Q0.16, rounded to nearest
  function automatic logic [15:0] tan_q16(input logic [4:0] k);
    logic [15:0] t;
    case (k)
      5'd1:    t = 16'd2289;
      5'd2:    t = 16'd4583;
      5'd3:    t = 16'd6888;
      5'd4:    t = 16'd9210;
      5'd5:    t = 16'd11556;
      5'd6:    t = 16'd13930;
      5'd7:    t = 16'd16340;
      5'd8:    t = 16'd18792;
      5'd9:    t = 16'd21294;
      5'd10:   t = 16'd23853;
      5'd11:   t = 16'd26478;
      5'd12:   t = 16'd29179;
      5'd13:   t = 16'd31964;
      5'd14:   t = 16'd34846;
      5'd15:   t = 16'd37837;
      5'd16:   t = 16'd40951;
      5'd17:   t = 16'd44205;
      5'd18:   t = 16'd47615;
      5'd19:   t = 16'd51202;
      5'd20:   t = 16'd54991;
      5'd21:   t = 16'd59009;
      5'd22:   t = 16'd63287;
      default: t = 16'd0;
    endcase
    return t;
  endfunction

  // Sector of a hue in 0..179
  function automatic sector_t sector_of(input logic [7:0] h);
    sector_t s;
    priority if (h >= 8'd150) s = SEC_MAG_RED;
    else if (h >= 8'd120)     s = SEC_BLU_MAG;
    else if (h >= 8'd90)      s = SEC_CYN_BLU;
    else if (h >= 8'd60)      s = SEC_GRN_CYN;
    else if (h >= 8'd30)      s = SEC_YEL_GRN;
    else                      s = SEC_RED_YEL;
    return s;
  endfunction

  // First hue of a sector
  function automatic logic [7:0] sector_base(input sector_t s);
    logic [7:0] b;
    unique case (s)
      SEC_RED_YEL: b = 8'd0;
      SEC_YEL_GRN: b = 8'd30;
      SEC_GRN_CYN: b = 8'd60;
      SEC_CYN_BLU: b = 8'd90;
      SEC_BLU_MAG: b = 8'd120;
      SEC_MAG_RED: b = 8'd150;
      default:     b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/ofc_front.sv
// Front end: abs and quadrant, gain multiply, clamp, square and sum of squares.
module ofc_front #(
  parameter int FLOW_WIDTH     = ofc_pkg::FLOW_WIDTH_DEF,
  parameter int FLOW_FRAC_BITS = ofc_pkg::FLOW_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [FLOW_WIDTH-1:0]    flow_x,
  input  logic signed [FLOW_WIDTH-1:0]    flow_y,
  input  logic [ofc_pkg::GAIN_WIDTH-1:0]  gain,
  output logic                            out_valid,
  output logic [FLOW_WIDTH-1:0]           out_a,
  output logic [FLOW_WIDTH-1:0]           out_b,
  output ofc_pkg::ofc_tag_t               out_tag
);
  import ofc_pkg::*;

  localparam int W  = FLOW_WIDTH;
  localparam int F  = FLOW_FRAC_BITS;
  localparam int GW = W + GAIN_WIDTH;          // gain * |component|
  localparam int CW = F + VALUE_BITS + 1;      // clamped product
  localparam int MW = (GW > CW) ? GW : CW;     // clamp compare width
  localparam int SW = 2 * CW;                  // square
  localparam int UW = SW + 1;                  // sum of squares
  localparam int HW = UW - 2 * F;              // sum in integer units
  localparam logic [MW-1:0] CLAMP_LIM = MW'(1) << (F + VALUE_BITS);

  // Stage 1: magnitudes and quadrant
  logic [W-1:0] xr, yr, ax_c, ay_c;
  logic         xneg, yneg, xzero, yzero;
  logic [1:0]   quad_c;
  logic         v1, zero1;
  logic [1:0]   quad1;
  logic [W-1:0] ax1, ay1;

  assign xr    = flow_x;
  assign yr    = flow_y;
  assign xneg  = xr[W-1];
  assign yneg  = yr[W-1];
  assign xzero = (xr == '0);
  assign yzero = (yr == '0);
  assign ax_c  = xneg ? ((~xr) + W'(1)) : xr;
  assign ay_c  = yneg ? ((~yr) + W'(1)) : yr;

  // quadrant of (-x, -y), boundaries as in the angle convention
  always_comb begin
    priority if (xneg && (yneg || yzero))          quad_c = 2'd0;
    else if (!xneg && yneg)                        quad_c = 2'd1;
    else if (!xneg && !xzero && !yneg)             quad_c = 2'd2;
    else                                           quad_c = 2'd3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1   <= ax_c;
      ay1   <= ay_c;
      quad1 <= quad_c;
      zero1 <= xzero && yzero;
    end
  end

  // Stage 2: major/minor axis, gain multiply
  logic           v2;
  logic [W-1:0]   a_c, b_c, a2, b2;
  logic [GW-1:0]  gx2, gy2;
  ofc_tag_t       tag_c, tag2;

  assign a_c = quad1[0] ? ay1 : ax1;
  assign b_c = quad1[0] ? ax1 : ay1;

  always_comb begin
    tag_c        = '0;
    tag_c.zero   = zero1;
    tag_c.steep  = (b_c > a_c);
    tag_c.quad   = quad1;
    tag_c.idx    = (b_c > a_c) ? IDX_STEEP_START : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2   <= a_c;
      b2   <= b_c;
      tag2 <= tag_c;
      gx2  <= GW'(gain) * GW'(ax1);
      gy2  <= GW'(gain) * GW'(ay1);
    end
  end

  // Stage 3: clamp, anything past 256 in integer units saturates the value
  logic           v3;
  logic [W-1:0]   a3, b3;
  ofc_tag_t       tag3;
  logic [MW-1:0]  gxm, gym;
  logic [CW-1:0]  gxc3, gyc3;

  assign gxm = MW'(gx2);
  assign gym = MW'(gy2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3   <= a2;
      b3   <= b2;
      tag3 <= tag2;
      gxc3 <= (gxm >= CLAMP_LIM) ? CW'(CLAMP_LIM) : CW'(gxm);
      gyc3 <= (gym >= CLAMP_LIM) ? CW'(CLAMP_LIM) : CW'(gym);
    end
  end

  // Stage 4: squares
  logic           v4;
  logic [W-1:0]   a4, b4;
  ofc_tag_t       tag4;
  logic [SW-1:0]  sqx4, sqy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a4   <= a3;
      b4   <= b3;
      tag4 <= tag3;
      sqx4 <= SW'(gxc3) * SW'(gxc3);
      sqy4 <= SW'(gyc3) * SW'(gyc3);
    end
  end

  // Stage 5: sum, drop fraction bits, saturate to 16 bits
  logic [UW-1:0]            sum_c;
  logic [HW-1:0]            hi_c;
  logic [MAG_SQ_WIDTH-1:0]  msq_c;
  ofc_tag_t                 tag5_c;

  assign sum_c = UW'(sqx4) + UW'(sqy4);
  assign hi_c  = sum_c[UW-1:2*F];
  assign msq_c = (|hi_c[HW-1:MAG_SQ_WIDTH]) ? '1 : hi_c[MAG_SQ_WIDTH-1:0];

  always_comb begin
    tag5_c        = tag4;
    tag5_c.mag_sq = msq_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_a   <= a4;
      out_b   <= b4;
      out_tag <= tag5_c;
    end
  end

endmodule

>>> hdl/ofc_angle_cell.sv
// Angle cell: one 2-degree boundary test by cross product against a fixed tangent.
module ofc_angle_cell #(
  parameter int FLOW_WIDTH = ofc_pkg::FLOW_WIDTH_DEF,
  parameter int STEP       = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [FLOW_WIDTH-1:0]  in_a,
  input  logic [FLOW_WIDTH-1:0]  in_b,
  input  ofc_pkg::ofc_tag_t      in_tag,
  output logic                   out_valid,
  output logic [FLOW_WIDTH-1:0]  out_a,
  output logic [FLOW_WIDTH-1:0]  out_b,
  output ofc_pkg::ofc_tag_t      out_tag
);
  import ofc_pkg::*;

  localparam int PW = FLOW_WIDTH + 16;
  localparam logic [15:0] TAN_K = tan_q16(5'(STEP));

  logic [FLOW_WIDTH-1:0] num, den;
  logic [PW-1:0]         shifted, prod;
  logic                  hit;
  ofc_tag_t              tag_next;

  // flat: b/a >= tan ; steep: a/b <= tan (counts down from 45 degrees)
  assign num     = in_tag.steep ? in_a : in_b;
  assign den     = in_tag.steep ? in_b : in_a;
  assign shifted = {num, 16'd0};
  assign prod    = PW'(TAN_K) * PW'(den);
  assign hit     = in_tag.steep ? (prod >= shifted) : (shifted >= prod);

  always_comb begin
    tag_next     = in_tag;
    tag_next.idx = in_tag.idx + 6'(hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_a   <= in_a;
      out_b   <= in_b;
      out_tag <= tag_next;
    end
  end

endmodule

>>> hdl/ofc_mag_cell.sv
// Magnitude cell: decides one bit of the value channel by a square compare.
module ofc_mag_cell #(
  parameter int BIT = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  ofc_pkg::ofc_tag_t  in_tag,
  output logic               out_valid,
  output ofc_pkg::ofc_tag_t  out_tag
);
  import ofc_pkg::*;

  logic [VALUE_BITS-1:0]   cand;
  logic [MAG_SQ_WIDTH-1:0] cand_sq;
  ofc_tag_t                tag_next;

  // keep the bit if the candidate squared still fits under the magnitude squared
  assign cand    = in_tag.value | (VALUE_BITS'(1) << BIT);
  assign cand_sq = MAG_SQ_WIDTH'(cand) * MAG_SQ_WIDTH'(cand);

  always_comb begin
    tag_next = in_tag;
    if (cand_sq <= in_tag.mag_sq) begin
      tag_next.value = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= tag_next;
    end
  end

endmodule

>>> hdl/ofc_color.sv
// HSV to BGR: hue and sector, rounded ramps, sector select.
module ofc_color (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  ofc_pkg::ofc_tag_t  in_tag,
  output logic               out_valid,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_green,
  output logic [7:0]         out_red
);
  import ofc_pkg::*;

  // Stage 1: hue, sector and offset inside the sector
  logic [7:0]            hue_c;
  sector_t               sec_c, sec1, sec2;
  logic [4:0]            r1;
  logic [VALUE_BITS-1:0] v1, v2;
  logic                  val1, val2;

  assign hue_c = in_tag.zero ? HUE_ZERO_VECTOR
                             : (8'(in_tag.quad) * QUAD_SPAN + 8'(in_tag.idx));
  assign sec_c = sector_of(hue_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      val1 <= 1'b0;
    end else if (en) begin
      val1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sec1 <= sec_c;
      r1   <= 5'(hue_c - sector_base(sec_c));
      v1   <= in_tag.value;
    end
  end

  // Stage 2: numerators 2*V*r + 30 and 2*V*(30-r) + 30
  logic [14:0] nt2, nq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      val2 <= 1'b0;
    end else if (en) begin
      val2 <= val1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sec2 <= sec1;
      v2   <= v1;
      nt2  <= ((15'(v1) * 15'(r1)) << 1) + ROUND_HALF;
      nq2  <= ((15'(v1) * 15'(SECTOR_SPAN - r1)) << 1) + ROUND_HALF;
    end
  end

  // Stage 3: divide by 60 via reciprocal, then pick channels by sector
  logic [29:0] pt, pq;
  logic [7:0]  t_c, q_c;
  logic [7:0]  b_c, g_c, r_c;

  assign pt  = 30'(nt2) * 30'(DIV60_RECIP);
  assign pq  = 30'(nq2) * 30'(DIV60_RECIP);
  assign t_c = pt[DIV60_SHIFT+7:DIV60_SHIFT];
  assign q_c = pq[DIV60_SHIFT+7:DIV60_SHIFT];

  always_comb begin
    unique case (sec2)
      SEC_RED_YEL: begin r_c = v2;   g_c = t_c;  b_c = 8'd0; end
      SEC_YEL_GRN: begin r_c = q_c;  g_c = v2;   b_c = 8'd0; end
      SEC_GRN_CYN: begin r_c = 8'd0; g_c = v2;   b_c = t_c;  end
      SEC_CYN_BLU: begin r_c = 8'd0; g_c = q_c;  b_c = v2;   end
      SEC_BLU_MAG: begin r_c = t_c;  g_c = 8'd0; b_c = v2;   end
      SEC_MAG_RED: begin r_c = v2;   g_c = 8'd0; b_c = q_c;  end
      default:     begin r_c = v2;   g_c = 8'd0; b_c = q_c;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= val2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_blue  <= b_c;
      out_green <= g_c;
      out_red   <= r_c;
    end
  end

endmodule

>>> hdl/optical_flow_to_color.sv
// Pipeline from an accepted flow request to color_valid: 5 front stages, 22 angle
// cells, 8 magnitude cells, 3 color stages, output register. Throughput: one flow
// request per cycle while flow_stall is low; every stage advances together and only
// the output skid register holds the chain when the color side stalls.
// Reset: synchronous rst clears all valid bits and loads magnitude gain 255.
module optical_flow_to_color #(
  parameter int FLOW_WIDTH     = ofc_pkg::FLOW_WIDTH_DEF,
  parameter int FLOW_FRAC_BITS = ofc_pkg::FLOW_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ofc_pkg::GAIN_WIDTH-1:0]  cfg_wdata,
  input  logic                            flow_valid,
  output logic                            flow_stall,
  input  logic signed [FLOW_WIDTH-1:0]    flow_x,
  input  logic signed [FLOW_WIDTH-1:0]    flow_y,
  output logic                            color_valid,
  input  logic                            color_stall,
  output logic [7:0]                      blue,
  output logic [7:0]                      green,
  output logic [7:0]                      red
);
  import ofc_pkg::*;

  logic                  en;
  logic [GAIN_WIDTH-1:0] magnitude_gain;

  // Gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude_gain <= GAIN_RESET;
    end else if (cfg_we) begin
      magnitude_gain <= cfg_wdata;
    end
  end

  // Front end
  logic                  ang_valid [0:ANGLE_STEPS];
  logic [FLOW_WIDTH-1:0] ang_a     [0:ANGLE_STEPS];
  logic [FLOW_WIDTH-1:0] ang_b     [0:ANGLE_STEPS];
  ofc_tag_t              ang_tag   [0:ANGLE_STEPS];

  ofc_front #(
    .FLOW_WIDTH     (FLOW_WIDTH),
    .FLOW_FRAC_BITS (FLOW_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (flow_valid),
    .flow_x    (flow_x),
    .flow_y    (flow_y),
    .gain      (magnitude_gain),
    .out_valid (ang_valid[0]),
    .out_a     (ang_a[0]),
    .out_b     (ang_b[0]),
    .out_tag   (ang_tag[0])
  );

  // Angle cells, one tangent boundary each
  for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_angle
    ofc_angle_cell #(
      .FLOW_WIDTH (FLOW_WIDTH),
      .STEP       (k + 1)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (ang_valid[k]),
      .in_a      (ang_a[k]),
      .in_b      (ang_b[k]),
      .in_tag    (ang_tag[k]),
      .out_valid (ang_valid[k+1]),
      .out_a     (ang_a[k+1]),
      .out_b     (ang_b[k+1]),
      .out_tag   (ang_tag[k+1])
    );
  end

  // Magnitude cells, one value bit each, MSB first
  logic     mag_valid [0:VALUE_BITS];
  ofc_tag_t mag_tag   [0:VALUE_BITS];

  assign mag_valid[0] = ang_valid[ANGLE_STEPS];
  assign mag_tag[0]   = ang_tag[ANGLE_STEPS];

  for (genvar j = 0; j < VALUE_BITS; j++) begin : g_mag
    ofc_mag_cell #(
      .BIT (VALUE_BITS - 1 - j)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (mag_valid[j]),
      .in_tag    (mag_tag[j]),
      .out_valid (mag_valid[j+1]),
      .out_tag   (mag_tag[j+1])
    );
  end

  // Color conversion
  logic       res_valid;
  logic [7:0] res_blue, res_green, res_red;

  ofc_color u_color (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mag_valid[VALUE_BITS]),
    .in_tag    (mag_tag[VALUE_BITS]),
    .out_valid (res_valid),
    .out_blue  (res_blue),
    .out_green (res_green),
    .out_red   (res_red)
  );

  // Output register plus skid: the chain moves whenever the skid is empty
  logic       skid_valid, skid_valid_next, color_valid_next;
  logic [7:0] skid_blue, skid_green, skid_red;
  logic       take, incoming, load_from_skid, load_from_res, load_skid;

  assign en         = !skid_valid;
  assign flow_stall = skid_valid;
  assign take       = color_valid && !color_stall;
  assign incoming   = en && res_valid;

  always_comb begin
    load_from_skid   = skid_valid && (take || !color_valid);
    load_from_res    = !skid_valid && incoming && (take || !color_valid);
    load_skid        = !skid_valid && incoming && color_valid && !take;
    color_valid_next = load_from_skid || load_from_res || (color_valid && !take);
    skid_valid_next  = load_skid || (skid_valid && !load_from_skid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else begin
      color_valid <= color_valid_next;
      skid_valid  <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_from_skid) begin
      blue  <= skid_blue;
      green <= skid_green;
      red   <= skid_red;
    end else if (load_from_res) begin
      blue  <= res_blue;
      green <= res_green;
      red   <= res_red;
    end
    if (load_skid) begin
      skid_blue  <= res_blue;
      skid_green <= res_green;
      skid_red   <= res_red;
    end
  end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the optical flow to color coder.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ofc_pkg::*;

  localparam int FW   = FLOW_WIDTH_DEF;
  localparam int FRAC = FLOW_FRAC_BITS_DEF;

  localparam logic [11:0] GAIN_AT_RESET  = 12'd255;
  localparam int unsigned HUE_OF_ZERO    = 90;
  localparam int unsigned HUE_PER_QUAD   = 45;
  localparam int unsigned HUE_PER_SECTOR = 30;
  localparam int          HOLD_LEN       = 200;
  localparam int          DRAIN_CYCLES   = 50;
  localparam int          MAX_PRINTS     = 40;

  // tan(2k degrees), unsigned Q0.16, rounded to nearest
  localparam int unsigned STEP_TAN [0:22] = '{
    0, 2289, 4583, 6888, 9210, 11556, 13930, 16340,
    18792, 21294, 23853, 26478, 29179, 31964, 34846, 37837,
    40951, 44205, 47615, 51202, 54991, 59009, 63287
  };

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } bgr_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [GAIN_WIDTH-1:0] cfg_wdata = '0;
  logic                  flow_valid = 1'b0;
  logic                  flow_stall;
  logic signed [FW-1:0]  flow_x = '0;
  logic signed [FW-1:0]  flow_y = '0;
  logic                  color_valid;
  logic                  color_stall = 1'b0;
  logic [7:0]            blue;
  logic [7:0]            green;
  logic [7:0]            red;

  bgr_t                  color_expected [$];
  bgr_t                  color_want;
  logic [GAIN_WIDTH-1:0] gain_now = GAIN_AT_RESET;
  bit                    quiet = 1'b0;
  bit                    hold_req = 1'b0;
  int                    hold_cycles = 0;
  int                    flows_sent = 0;
  int                    colors_checked = 0;
  int                    gains_used = 0;
  int                    in_stall_cycles = 0;
  int                    fail_count = 0;

  optical_flow_to_color #(
    .FLOW_WIDTH     (FW),
    .FLOW_FRAC_BITS (FRAC)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .flow_valid  (flow_valid),
    .flow_stall  (flow_stall),
    .flow_x      (flow_x),
    .flow_y      (flow_y),
    .color_valid (color_valid),
    .color_stall (color_stall),
    .blue        (blue),
    .green       (green),
    .red         (red)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Largest v in 0..255 with (v * 2^FRAC)^2 <= s * gain^2
  function automatic int unsigned flow_value(longint unsigned s, int unsigned g);
    longint unsigned lim;
    longint unsigned sc;
    int unsigned     v;
    int unsigned     cand;
    int              bi;
    lim = s * g * g;
    v = 0;
    for (bi = 7; bi >= 0; bi--) begin
      cand = v | (32'd1 << bi);
      sc = longint'(cand) << FRAC;
      if (sc * sc <= lim) v = cand;
    end
    return v;
  endfunction

  // Direction of the reversed vector in 2-degree steps, 0..179
  function automatic int unsigned flow_hue(longint x, longint y);
    longint          u;
    longint          w;
    longint unsigned a;
    longint unsigned b;
    int unsigned     quad;
    int unsigned     idx;
    int              k;
    u = -x;
    w = -y;
    idx = 0;
    if (u == 0 && w == 0) return HUE_OF_ZERO;
    if (u > 0 && w >= 0) begin
      quad = 0; a = u;  b = w;
    end else if (u <= 0 && w > 0) begin
      quad = 1; a = w;  b = -u;
    end else if (u < 0 && w <= 0) begin
      quad = 2; a = -u; b = -w;
    end else begin
      quad = 3; a = -w; b = u;
    end
    // on a boundary counts as past it
    if (b <= a) begin
      for (k = 1; k <= 22; k++)
        if ((b << 16) >= STEP_TAN[k] * a) idx++;
    end else begin
      idx = 22;
      for (k = 1; k <= 22; k++)
        if ((a << 16) <= STEP_TAN[k] * b) idx++;
    end
    return quad * HUE_PER_QUAD + idx;
  endfunction

  // Expected pixel for one flow request
  function automatic bgr_t flow_color(logic signed [FW-1:0] fx, logic signed [FW-1:0] fy,
                                      logic [GAIN_WIDTH-1:0] g);
    longint          x;
    longint          y;
    longint unsigned s;
    int unsigned     v;
    int unsigned     h;
    int unsigned     r;
    int unsigned     t;
    int unsigned     q;
    sector_t         sec;
    bgr_t            c;
    x = longint'(fx);
    y = longint'(fy);
    s = x * x + y * y;
    v = flow_value(s, 32'(g));
    h = flow_hue(x, y);
    sec = sector_t'(h / HUE_PER_SECTOR);
    r = h % HUE_PER_SECTOR;
    t = (2 * v * r + 30) / 60;
    q = (2 * v * (30 - r) + 30) / 60;
    case (sec)
      SEC_RED_YEL: begin c.red = 8'(v); c.green = 8'(t); c.blue = 8'd0;  end
      SEC_YEL_GRN: begin c.red = 8'(q); c.green = 8'(v); c.blue = 8'd0;  end
      SEC_GRN_CYN: begin c.red = 8'd0;  c.green = 8'(v); c.blue = 8'(t); end
      SEC_CYN_BLU: begin c.red = 8'd0;  c.green = 8'(q); c.blue = 8'(v); end
      SEC_BLU_MAG: begin c.red = 8'(t); c.green = 8'd0;  c.blue = 8'(v); end
      default:     begin c.red = 8'(v); c.green = 8'd0;  c.blue = 8'(q); end
    endcase
    return c;
  endfunction

  // One line per failure, print count capped
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Offer one flow request; returns at the falling edge after acceptance
  task automatic send_flow(input logic signed [FW-1:0] x, input logic signed [FW-1:0] y);
    bgr_t want;
    want = flow_color(x, y, gain_now);
    if (!quiet && $urandom_range(99) < 10) begin
      flow_valid <= 1'b0;
      @(negedge clk);
    end
    flow_valid <= 1'b1;
    flow_x     <= x;
    flow_y     <= y;
    do @(posedge clk); while (flow_stall);
    color_expected.insert(color_expected.size(), want);
    flows_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait for every pending color
  task automatic settle();
    flow_valid <= 1'b0;
    while (color_expected.size() != 0) @(negedge clk);
  endtask

  // Gain change only with the pipeline empty
  task automatic write_gain(input logic [GAIN_WIDTH-1:0] g);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_we   <= 1'b0;
    gain_now = g;
    gains_used++;
  endtask

  // Random flow vector, mixed shapes
  task automatic pick_flow(output logic signed [FW-1:0] x, output logic signed [FW-1:0] y);
    int span;
    int a;
    int d;
    case ($urandom_range(0, 3))
      0: begin
        x = FW'($urandom);
        y = FW'($urandom);
      end
      1: begin
        span = 1 << $urandom_range(0, 15);
        x = FW'(int'($urandom_range(0, 2 * span)) - span);
        y = FW'(int'($urandom_range(0, 2 * span)) - span);
      end
      2: begin
        // close to an axis
        a = int'($urandom);
        d = int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(1)) begin
          x = FW'(a); y = FW'(d);
        end else begin
          x = FW'(d); y = FW'(a);
        end
      end
      default: begin
        // close to a diagonal
        span = 1 << $urandom_range(0, 14);
        a = int'($urandom_range(0, 2 * span)) - span;
        d = int'($urandom_range(0, 4)) - 2;
        x = FW'(a);
        y = $urandom_range(1) ? FW'(a + d) : FW'(-a + d);
      end
    endcase
  endtask

  // Color side: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && hold_cycles < HOLD_LEN) begin
      color_stall <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      color_stall <= !quiet && ($urandom_range(99) < 10);
    end
  end

  // Compare each accepted color with the oldest pending one
  always @(posedge clk) begin
    if (!rst && flow_valid && flow_stall) in_stall_cycles++;
    if (!rst && color_valid && !color_stall) begin
      if (color_expected.size() == 0) begin
        note_failure($sformatf("unexpected color b=%0d g=%0d r=%0d", blue, green, red));
      end else begin
        color_want = color_expected.pop_front();
        if (blue !== color_want.blue)
          note_failure($sformatf("color %0d blue got %0d want %0d",
                                 colors_checked, blue, color_want.blue));
        if (green !== color_want.green)
          note_failure($sformatf("color %0d green got %0d want %0d",
                                 colors_checked, green, color_want.green));
        if (red !== color_want.red)
          note_failure($sformatf("color %0d red got %0d want %0d",
                                 colors_checked, red, color_want.red));
        colors_checked++;
      end
    end
  end

  // Default gain: axes, diagonals, extremes, hue boundaries
  task automatic test_reset_gain();
    send_flow(0, 0);              // zero vector gives black
    send_flow(-32768, -32768);    // most negative on both
    send_flow(32767, 32767);
    send_flow(-32768, 32767);
    send_flow(32767, -32768);
    send_flow(-4096, 0);          // hue 0
    send_flow(0, -4096);          // hue 45
    send_flow(4096, 0);           // hue 90
    send_flow(0, 4096);           // hue 135
    send_flow(-32768, 1);         // just short of a full turn
    send_flow(-16384, -1722);     // exactly on the 6 degree line
    send_flow(-16384, -1721);     // just below it
    send_flow(-3000, -3000);      // 45 degree diagonal
    send_flow(-17, 0);            // value barely 1
    send_flow(-1536, -2048);      // mid value, exact magnitude
  endtask

  // Gain register at its limits and at zero
  task automatic test_gain_extremes();
    write_gain(12'd1);
    send_flow(-32768, -32768);
    send_flow(-32768, 0);
    send_flow(5000, -7000);
    write_gain(12'd4095);
    send_flow(-1, 0);
    send_flow(-2, 0);
    send_flow(-2, -1);
    write_gain(12'd0);
    send_flow(-32768, -32768);
    send_flow(100, -50);
  endtask

  // Random vectors over several gain settings, with idling
  task automatic test_random_gains();
    logic [GAIN_WIDTH-1:0] g;
    logic signed [FW-1:0]  x;
    logic signed [FW-1:0]  y;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0:       g = GAIN_WIDTH'($urandom_range(1, 300));
        1:       g = GAIN_WIDTH'($urandom_range(1, 4095));
        2:       g = (ph == 2) ? 12'd1 : 12'd4095;
        default: g = GAIN_AT_RESET;
      endcase
      write_gain(g);
      repeat (100) begin
        pick_flow(x, y);
        send_flow(x, y);
      end
    end
  endtask

  // Back-to-back requests, no idling on either side
  task automatic test_steady_stream();
    logic signed [FW-1:0] x;
    logic signed [FW-1:0] y;
    write_gain(GAIN_WIDTH'($urandom_range(1, 600)));
    quiet = 1'b1;
    repeat (150) begin
      pick_flow(x, y);
      send_flow(x, y);
    end
    quiet = 1'b0;
    settle();
  endtask

  // Long hold-off on the color side so the pipeline fills and stalls flow
  task automatic test_output_hold_off();
    logic signed [FW-1:0] x;
    logic signed [FW-1:0] y;
    write_gain(GAIN_WIDTH'($urandom_range(1, 4095)));
    hold_req <= 1'b1;
    repeat (200) begin
      pick_flow(x, y);
      send_flow(x, y);
    end
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_gain();
    test_gain_extremes();
    test_random_gains();
    test_steady_stream();
    test_output_hold_off();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (color_expected.size() != 0)
      note_failure($sformatf("%0d colors never arrived", color_expected.size()));

    $display("Sent %0d flow requests over %0d gain writes, checked %0d colors.",
             flows_sent, gains_used, colors_checked);
    $display("Flow side was held for %0d cycles, including one %0d-cycle output hold-off.",
             in_stall_cycles, HOLD_LEN);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("TIMEOUT: %0d colors still pending", color_expected.size());
    $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
hdl/ofc_pkg.sv
hdl/ofc_front.sv
hdl/ofc_angle_cell.sv
hdl/ofc_mag_cell.sv
hdl/ofc_color.sv
hdl/optical_flow_to_color.sv
dv/testbench.sv
